// File: rtl/sga_pkg.sv
// Shared types and constants of the spike gated synapse accumulator.
// No dependencies; every other file of the block but sga_fifo refers to it by scoped names.
`default_nettype none

package sga_pkg;

  // Fixed field widths
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int SAMPLE_W   = 16;
  localparam int CURR_W     = 32;
  localparam int IN_TDATA_W = 64;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  // Queue depths between front, back and output
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_VALUED = 2'd2;

  // Operation carried by an input transaction
  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_PRESET = 2'd1,
    OP_PRE    = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ACCUM,
    BK_DRAIN,
    BK_READ
  } bk_state_t;

  // Classified command from front to back, with the config it ran under
  typedef struct packed {
    op_t                        op;
    logic [IDX_W-1:0]           post;
    logic [IDX_W-1:0]           pre;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [CURR_W-1:0]   preset;
    logic [CNT_W-1:0]           npost;
    logic                       real_mode;
  } cmd_t;

  // One readout result
  typedef struct packed {
    logic                     last;
    logic signed [CURR_W-1:0] current;
    logic [IDX_W-1:0]         idx;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/sga_fifo.sv
// Small register FIFO used for the command queue and the result queue.
// Depends on nothing; width and depth come from parameters.
`default_nettype none

module sga_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entry data
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sga_front.sv
// Front end: configuration registers, input acceptance and range classification.
// Depends on sga_pkg; pushes classified commands into the command queue.
`default_nettype none

module sga_front #(
  parameter int PRE_MAX  = 64,
  parameter int POST_MAX = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [sga_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire logic [sga_pkg::IN_TUSER_W-1:0]      in_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sga_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sga_pkg::CNT_W-1:0]           cfg_data,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output sga_pkg::cmd_t                            q_cmd
);

  logic [sga_pkg::CNT_W-1:0] pre_count_r, post_count_r;
  logic                      real_r;
  logic [sga_pkg::CNT_W-1:0] npre, npost;
  sga_pkg::op_t              mode;
  logic [sga_pkg::IDX_W-1:0] post_idx, pre_idx;
  logic                      post_ok, pre_ok, keep;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_count_r  <= sga_pkg::CNT_W'(64);
      post_count_r <= sga_pkg::CNT_W'(64);
      real_r       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sga_pkg::CFG_PRE_COUNT:   pre_count_r  <= cfg_data;
        sga_pkg::CFG_POST_COUNT:  post_count_r <= cfg_data;
        sga_pkg::CFG_REAL_VALUED: real_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp active counts into 1..MAX
  always_comb begin
    if (pre_count_r == '0) begin
      npre = sga_pkg::CNT_W'(1);
    end else if (int'(pre_count_r) > PRE_MAX) begin
      npre = sga_pkg::CNT_W'(PRE_MAX);
    end else begin
      npre = pre_count_r;
    end
    if (post_count_r == '0) begin
      npost = sga_pkg::CNT_W'(1);
    end else if (int'(post_count_r) > POST_MAX) begin
      npost = sga_pkg::CNT_W'(POST_MAX);
    end else begin
      npost = post_count_r;
    end
  end

  // Unpack and classify the transaction; drop out-of-range items
  assign mode     = sga_pkg::op_t'(in_tuser);
  assign post_idx = in_tdata[5:0];
  assign pre_idx  = in_tdata[11:6];
  assign post_ok  = ({1'b0, post_idx} < npost);
  assign pre_ok   = ({1'b0, pre_idx} < npre);

  always_comb begin
    unique case (mode)
      sga_pkg::OP_WEIGHT: keep = post_ok & pre_ok;
      sga_pkg::OP_PRESET: keep = post_ok;
      sga_pkg::OP_PRE:    keep = pre_ok;
      sga_pkg::OP_READ:   keep = 1'b1;
    endcase
  end

  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full & keep;

  always_comb begin
    q_cmd.op        = mode;
    q_cmd.post      = post_idx;
    q_cmd.pre       = pre_idx;
    q_cmd.sample    = in_tdata[27:12];
    q_cmd.preset    = in_tdata[59:28];
    q_cmd.npost     = npost;
    q_cmd.real_mode = real_r;
  end

endmodule

`default_nettype wire

// File: rtl/sga_back.sv
// Back end: weight and current memories, accumulate pipeline, readout sequencer.
// Depends on sga_pkg and sga_fifo (result queue).
`default_nettype none

module sga_back #(
  parameter int PRE_MAX  = 64,
  parameter int POST_MAX = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  input  wire sga_pkg::cmd_t  cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sga_pkg::res_t       out_res
);

  localparam int PRE_AW  = (PRE_MAX > 1) ? $clog2(PRE_MAX) : 1;
  localparam int POST_AW = (POST_MAX > 1) ? $clog2(POST_MAX) : 1;
  localparam int WA_W    = POST_AW + PRE_AW;
  localparam int W_DEPTH = 1 << WA_W;
  localparam int OCW     = $clog2(sga_pkg::OUT_DEPTH + 1);

  sga_pkg::bk_state_t state_r, state_nxt;

  logic [POST_AW-1:0]  cnt_r, cnt_nxt;
  logic [POST_AW-1:0]  last_r;
  logic [PRE_AW-1:0]   pre_r;
  logic signed [15:0]  sample_r;
  logic                real_r;

  logic wm_we, am_we_pre, am_re_acc, rd_issue, room;

  logic signed [15:0] wmem [W_DEPTH];
  logic signed [31:0] amem [POST_MAX];
  logic signed [15:0] w_rd_r;
  logic signed [31:0] a_rd_r;

  logic               am_we;
  logic [POST_AW-1:0] am_waddr;
  logic signed [31:0] am_wdata;

  // Accumulate pipeline
  logic               v1_r, v2_r, v3_r;
  logic [POST_AW-1:0] i1_r, i2_r, i3_r;
  logic signed [31:0] prod_c, prod2_r, rnd_c;
  logic signed [15:0] spk_c, spk2_r;
  logic signed [31:0] acc2_r, acc3_r;
  logic signed [19:0] term_c, term3_r;
  logic signed [32:0] sum_c;
  logic signed [31:0] sat_c;

  // Readout in flight
  logic               pend_r, pend_last_r;
  logic [POST_AW-1:0] pend_idx_r;
  sga_pkg::res_t      push_res;
  logic               out_empty;
  logic [OCW-1:0]     out_count;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sga_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            sga_pkg::OP_PRE:    state_nxt = sga_pkg::BK_ACCUM;
            sga_pkg::OP_READ:   state_nxt = sga_pkg::BK_READ;
            sga_pkg::OP_WEIGHT,
            sga_pkg::OP_PRESET: state_nxt = sga_pkg::BK_IDLE;
          endcase
        end
      end
      sga_pkg::BK_ACCUM: begin
        if (cnt_r == last_r) state_nxt = sga_pkg::BK_DRAIN;
      end
      sga_pkg::BK_DRAIN: begin
        if (!(v1_r | v2_r | v3_r)) state_nxt = sga_pkg::BK_IDLE;
      end
      sga_pkg::BK_READ: begin
        if (rd_issue && cnt_r == last_r) state_nxt = sga_pkg::BK_IDLE;
      end
    endcase
  end

  assign room = (int'(out_count) + int'(pend_r)) < sga_pkg::OUT_DEPTH;

  // State outputs
  always_comb begin
    cmd_pop   = 1'b0;
    wm_we     = 1'b0;
    am_we_pre = 1'b0;
    am_re_acc = 1'b0;
    rd_issue  = 1'b0;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      sga_pkg::BK_IDLE: begin
        cmd_pop   = cmd_valid;
        wm_we     = cmd_valid & (cmd.op == sga_pkg::OP_WEIGHT);
        am_we_pre = cmd_valid & (cmd.op == sga_pkg::OP_PRESET);
        cnt_nxt   = '0;
      end
      sga_pkg::BK_ACCUM: begin
        am_re_acc = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
      end
      sga_pkg::BK_DRAIN: ;
      sga_pkg::BK_READ: begin
        rd_issue = room;
        if (room) cnt_nxt = cnt_r + 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sga_pkg::BK_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Latch the operands of a pass or readout
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      pre_r    <= PRE_AW'(cmd.pre);
      sample_r <= cmd.sample;
      real_r   <= cmd.real_mode;
      last_r   <= POST_AW'(cmd.npost - 7'd1);
    end
  end

  // Weight memory: write from idle, read during a pass
  always_ff @(posedge clk) begin
    if (wm_we) begin
      wmem[{POST_AW'(cmd.post), PRE_AW'(cmd.pre)}] <= cmd.sample;
    end
    if (am_re_acc) begin
      w_rd_r <= wmem[{cnt_r, pre_r}];
    end
  end

  // Current memory: one write port (preset or write-back), one read port
  assign am_we    = am_we_pre | v3_r;
  assign am_waddr = am_we_pre ? POST_AW'(cmd.post) : i3_r;
  assign am_wdata = am_we_pre ? cmd.preset : sat_c;

  always_ff @(posedge clk) begin
    if (am_we) begin
      amem[am_waddr] <= am_wdata;
    end
    if (am_re_acc | rd_issue) begin
      a_rd_r <= amem[cnt_r];
    end
  end

  // Stage 2: multiply, or gate the weight on a positive spike
  assign prod_c = w_rd_r * sample_r;
  assign spk_c  = (sample_r > 16'sd0) ? w_rd_r : 16'sd0;

  // Stage 3: round Q7.24 to Q19.12, nearest with ties up
  assign rnd_c  = (prod2_r + 32'sd2048) >>> 12;
  assign term_c = real_r ? rnd_c[19:0] : {{4{spk2_r[15]}}, spk2_r};

  // Stage 4: saturating add and write-back
  assign sum_c = {acc3_r[31], acc3_r} + {{13{term3_r[19]}}, term3_r};
  assign sat_c = (sum_c[32] != sum_c[31]) ?
                 (sum_c[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum_c[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      v1_r   <= am_re_acc;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      pend_r <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    i1_r        <= cnt_r;
    i2_r        <= i1_r;
    prod2_r     <= prod_c;
    spk2_r      <= spk_c;
    acc2_r      <= a_rd_r;
    i3_r        <= i2_r;
    term3_r     <= term_c;
    acc3_r      <= acc2_r;
    pend_idx_r  <= cnt_r;
    pend_last_r <= (cnt_r == last_r);
  end

  // Queue readout results toward the output port
  always_comb begin
    push_res.last    = pend_last_r;
    push_res.current = a_rd_r;
    push_res.idx     = sga_pkg::IDX_W'(pend_idx_r);
  end

  sga_fifo #(
    .WIDTH ($bits(sga_pkg::res_t)),
    .DEPTH (sga_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (pend_r),
    .wdata (push_res),
    .pop   (out_ready),
    .rdata (out_res),
    .full  (),
    .empty (out_empty),
    .count (out_count)
  );

  assign out_valid = ~out_empty;

endmodule

`default_nettype wire

// File: rtl/spike_gated_synapse_accumulator.sv
// A weight write or preset retires from the idle state as it is popped; a presynaptic
// value holds the back end for the pop, one read-modify-write per active neuron and
// the pipeline drain. Readout: results come in neuron index order, issued while the
// result queue has room and drained while out_tready stays high.
// A 2-entry command queue lets input run ahead of the back end. Reset (rst_n low,
// synchronous) clears control, queues and config to 64/64/spike; memories keep contents.
`default_nettype none

module spike_gated_synapse_accumulator #(
  parameter int PRE_MAX  = 64,
  parameter int POST_MAX = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: post_index[5:0], pre_index[11:6], sample_value[27:12],
  //           preset_current[59:28], zero[63:60]
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [sga_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: mode[1:0]
  input  wire logic [sga_pkg::IN_TUSER_W-1:0]   in_tuser,
  // out_tdata: neuron_index[5:0], neuron_current[37:6], zero[39:38]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [sga_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sga_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sga_pkg::CNT_W-1:0]        cfg_data
);

  logic          q_push, q_full, q_empty, q_pop;
  sga_pkg::cmd_t q_wcmd, q_rcmd;
  sga_pkg::res_t res;

  sga_front #(
    .PRE_MAX  (PRE_MAX),
    .POST_MAX (POST_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_wcmd)
  );

  // Command queue between front and back
  sga_fifo #(
    .WIDTH ($bits(sga_pkg::cmd_t)),
    .DEPTH (sga_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wcmd),
    .pop   (q_pop),
    .rdata (q_rcmd),
    .full  (q_full),
    .empty (q_empty),
    .count ()
  );

  sga_back #(
    .PRE_MAX  (PRE_MAX),
    .POST_MAX (POST_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (~q_empty),
    .cmd       (q_rcmd),
    .cmd_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result transaction
  assign out_tdata = {2'b00, res.current, res.idx};
  assign out_tlast = res.last;

endmodule

`default_nettype wire

// File: rtl/sga_checker.sv
// Port-level checks of the result stream, bound to the top level.
// Depends on sga_pkg for the result bus width.
`default_nettype none

module sga_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [sga_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic                              out_tlast
);

  logic [sga_pkg::IDX_W-1:0] exp_idx_r;

  // Track the neuron index the next result must carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_tvalid && out_tready) begin
      exp_idx_r <= out_tlast ? '0 : out_tdata[5:0] + 1'b1;
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |-> out_tdata[5:0] == exp_idx_r)
    else $error("readout index out of order");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind spike_gated_synapse_accumulator sga_checker u_sga_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
